[hdl/fpa_pkg.sv]
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int NUM_W     = 34 + FRAC_BITS;
    localparam int REM_W     = 33;

    localparam logic [63:0] MUL_HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [31:0] TOINT_BIAS = 32'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam logic [63:0] LIM_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM_NEG = 64'h0000_0000_8000_0000;

    typedef enum logic [3:0] {
        KIND_ADD  = 4'd0,
        KIND_SUB  = 4'd1,
        KIND_MUL  = 4'd2,
        KIND_DIV  = 4'd3,
        KIND_INC  = 4'd4,
        KIND_DEC  = 4'd5,
        KIND_TOI  = 4'd6,
        KIND_FROMI = 4'd7,
        KIND_MIN  = 4'd8,
        KIND_MAX  = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]        kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]       mag_a;
        logic [31:0]       mag_b;
        logic              neg;
        logic              less;
        logic              equal;
        logic              greater;
    } s1_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [63:0]        prod;
        logic signed [31:0] simple;
        logic               simple_ovf;
        logic               neg;
        logic               div0;
        logic               less;
        logic               equal;
        logic               greater;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] quo;
        logic [REM_W-1:0] d;
    } div_t;

    function automatic div_t div_step(div_t x);
        div_t             y;
        logic [REM_W:0]   t;
        logic             qb;
        t  = {x.rem, x.num[NUM_W-1]};
        qb = (t >= {1'b0, x.d});
        y  = x;
        y.rem = qb ? REM_W'(t - {1'b0, x.d}) : t[REM_W-1:0];
        y.num = {x.num[NUM_W-2:0], 1'b0};
        y.quo = {x.quo[NUM_W-2:0], qb};
        return y;
    endfunction

endpackage

[hdl/fpa_req_if.sv]
interface fpa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic signed [31:0] a_raw;
    logic signed [31:0] b_raw;

    modport source (output valid, kind, a_raw, b_raw, input ready);
    modport sink   (input valid, kind, a_raw, b_raw, output ready);
endinterface

[hdl/fpa_rsp_if.sv]
interface fpa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               less;
    logic               equal;
    logic               greater;
    logic [1:0]         status;

    modport source (output valid, value, less, equal, greater, status, input ready);
    modport sink   (input valid, value, less, equal, greater, status, output ready);
endinterface

[hdl/fixed_point_alu_core.sv]
// Signed 32-bit fixed-point ALU, Q(31-F).F with F = FRAC_BITS (8).
// req: sink channel carrying kind, a_raw, b_raw; one transaction per operation.
// rsp: source channel carrying value, less/equal/greater and status;
//      exactly one rsp transaction per req transaction, in order.
// Operations: add, sub, mul, div (round half away from zero), inc, dec,
// to int, from int, min, max. Overflow saturates with status 1; divide by
// zero gives value 0 and status 2. Flags always compare a_raw with b_raw.
// Pipeline: two input stages, the divider of NUM_W = 34 + F restoring
// stages, one quotient bit each, and two output stages. Every operation
// passes through the full pipeline.
// Throughput: one transaction per cycle while rsp is not stalled.
// The pipeline advances whenever the output register is empty or being
// taken; while rsp is stalled with a result held, the whole pipeline holds
// and req.ready is low. Nothing is dropped or repeated.
// Reset clears all valid bits; the block accepts right after reset.
module fixed_point_alu_core (
    input  logic clk,
    input  logic rst_n,
    fpa_req_if.sink   req,
    fpa_rsp_if.source rsp
);
    import fpa_pkg::*;

    logic  en;
    logic  fr_vld;
    div_t  fr_div;
    side_t fr_side;
    logic  dv_vld;
    logic [NUM_W-1:0] dv_quo;
    side_t dv_side;

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .kind      (req.kind),
        .a_raw     (req.a_raw),
        .b_raw     (req.b_raw),
        .out_valid (fr_vld),
        .out_div   (fr_div),
        .out_side  (fr_side)
    );

    fpa_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_vld),
        .in_div    (fr_div),
        .in_side   (fr_side),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .out_side  (dv_side)
    );

    fpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_vld),
        .quo       (dv_quo),
        .in_side   (dv_side),
        .out_valid (rsp.valid),
        .value     (rsp.value),
        .less      (rsp.less),
        .equal     (rsp.equal),
        .greater   (rsp.greater),
        .status    (rsp.status)
    );
endmodule

[hdl/fpa_front.sv]
module fpa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [3:0]          kind,
    input  logic signed [31:0]  a_raw,
    input  logic signed [31:0]  b_raw,
    output logic                out_valid,
    output fpa_pkg::div_t       out_div,
    output fpa_pkg::side_t      out_side
);
    import fpa_pkg::*;

    logic  s1_vld_reg;
    s1_t   s1_reg, s1_next;
    logic  s2_vld_reg;
    div_t  div_reg, div_next;
    side_t side_reg, side_next;

    always_comb
    begin
        s1_next.kind    = kind;
        s1_next.a       = a_raw;
        s1_next.b       = b_raw;
        s1_next.mag_a   = a_raw[31] ? 32'(-a_raw) : 32'(a_raw);
        s1_next.mag_b   = b_raw[31] ? 32'(-b_raw) : 32'(b_raw);
        s1_next.neg     = a_raw[31] ^ b_raw[31];
        s1_next.less    = a_raw < b_raw;
        s1_next.equal   = a_raw == b_raw;
        s1_next.greater = a_raw > b_raw;
    end

    logic [32:0]         add_x;
    logic                add_sub;
    logic [32:0]         add_sum;
    logic                add_ovf;
    logic signed [31:0]  toi_sum;
    logic [FRAC_BITS:0]  fi_hi;
    logic                fi_ovf;

    always_comb
    begin
        add_sub = (s1_reg.kind == KIND_SUB) || (s1_reg.kind == KIND_DEC);
        if ((s1_reg.kind == KIND_INC) || (s1_reg.kind == KIND_DEC))
            add_x = 33'd1;
        else
            add_x = {s1_reg.b[31], s1_reg.b};
        add_sum = {s1_reg.a[31], s1_reg.a} + (add_sub ? ~add_x : add_x) + 33'(add_sub);
        add_ovf = add_sum[32] ^ add_sum[31];
        toi_sum = s1_reg.a + (s1_reg.a[31] ? $signed(TOINT_BIAS) : 32'sd0);
        fi_hi   = s1_reg.a[31:31-FRAC_BITS];
        fi_ovf  = (fi_hi != '0) && (fi_hi != '1);

        side_next.kind       = s1_reg.kind;
        side_next.prod       = 64'(s1_reg.mag_a) * 64'(s1_reg.mag_b);
        side_next.neg        = s1_reg.neg;
        side_next.div0       = (s1_reg.mag_b == 32'd0);
        side_next.less       = s1_reg.less;
        side_next.equal      = s1_reg.equal;
        side_next.greater    = s1_reg.greater;
        side_next.simple     = 32'sd0;
        side_next.simple_ovf = 1'b0;
        case (s1_reg.kind) inside
            KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC:
            begin
                side_next.simple_ovf = add_ovf;
                if (add_ovf)
                    side_next.simple = add_sum[32] ? SAT_MIN : SAT_MAX;
                else
                    side_next.simple = $signed(add_sum[31:0]);
            end
            KIND_TOI:
                side_next.simple = toi_sum >>> FRAC_BITS;
            KIND_FROMI:
            begin
                side_next.simple_ovf = fi_ovf;
                if (fi_ovf)
                    side_next.simple = s1_reg.a[31] ? SAT_MIN : SAT_MAX;
                else
                    side_next.simple = s1_reg.a <<< FRAC_BITS;
            end
            KIND_MIN:
                side_next.simple = s1_reg.less ? s1_reg.a : s1_reg.b;
            KIND_MAX:
                side_next.simple = s1_reg.greater ? s1_reg.a : s1_reg.b;
            default:
                side_next.simple = 32'sd0;
        endcase

        div_next.num = NUM_W'({s1_reg.mag_a, {(FRAC_BITS + 1){1'b0}}})
                     + NUM_W'(s1_reg.mag_b);
        div_next.d   = {s1_reg.mag_b, 1'b0};
        div_next.rem = '0;
        div_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            div_reg  <= div_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = s2_vld_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;
endmodule

[hdl/fpa_divider.sv]
module fpa_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  fpa_pkg::div_t  in_div,
    input  fpa_pkg::side_t in_side,
    output logic           out_valid,
    output logic [fpa_pkg::NUM_W-1:0] quo,
    output fpa_pkg::side_t out_side
);
    import fpa_pkg::*;

    logic [NUM_W-1:0] vld_reg;
    div_t             dat_reg [NUM_W];
    side_t            sb_reg  [NUM_W];

    // one quotient bit per stage, restoring
    for (genvar gi = 0; gi < NUM_W; gi++)
    begin : g_stage
        logic  vld_next;
        div_t  dat_next;
        side_t sb_next;

        if (gi == 0)
        begin : g_first
            assign vld_next = in_valid;
            assign dat_next = div_step(in_div);
            assign sb_next  = in_side;
        end
        else
        begin : g_rest
            assign vld_next = vld_reg[gi-1];
            assign dat_next = div_step(dat_reg[gi-1]);
            assign sb_next  = sb_reg[gi-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[gi] <= 1'b0;
            else if (en)
                vld_reg[gi] <= vld_next;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dat_reg[gi] <= dat_next;
                sb_reg[gi]  <= sb_next;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quo       = dat_reg[NUM_W-1].quo;
    assign out_side  = sb_reg[NUM_W-1];
endmodule

[hdl/fpa_back.sv]
module fpa_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [fpa_pkg::NUM_W-1:0]  quo,
    input  fpa_pkg::side_t             in_side,
    output logic                       out_valid,
    output logic signed [31:0]         value,
    output logic                       less,
    output logic                       equal,
    output logic                       greater,
    output logic [1:0]                 status
);
    import fpa_pkg::*;

    logic               p1_vld_reg;
    logic [63:0]        mag_reg, mag_next;
    side_t              side_reg;
    logic               p2_vld_reg;
    logic signed [31:0] value_reg, value_next;
    logic [2:0]         flags_reg;
    logic [1:0]         status_reg, status_next;

    logic               ovf;
    logic signed [31:0] sat_val;

    always_comb
    begin
        if (in_side.kind == KIND_MUL)
            mag_next = (in_side.prod + MUL_HALF) >> FRAC_BITS;
        else
            mag_next = 64'(quo);
    end

    always_comb
    begin
        ovf = side_reg.neg ? (mag_reg > LIM_NEG) : (mag_reg > LIM_POS);
        if (ovf)
            sat_val = side_reg.neg ? SAT_MIN : SAT_MAX;
        else
            sat_val = side_reg.neg ? $signed(-mag_reg[31:0]) : $signed(mag_reg[31:0]);

        value_next  = side_reg.simple;
        status_next = side_reg.simple_ovf ? ST_OVF : ST_OK;
        case (side_reg.kind)
            KIND_MUL:
            begin
                value_next  = sat_val;
                status_next = ovf ? ST_OVF : ST_OK;
            end
            KIND_DIV:
            begin
                if (side_reg.div0)
                begin
                    value_next  = 32'sd0;
                    status_next = ST_DIV0;
                end
                else
                begin
                    value_next  = sat_val;
                    status_next = ovf ? ST_OVF : ST_OK;
                end
            end
            default:
            begin
                value_next  = side_reg.simple;
                status_next = side_reg.simple_ovf ? ST_OVF : ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= in_valid;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg    <= mag_next;
            side_reg   <= in_side;
            value_reg  <= value_next;
            flags_reg  <= {side_reg.less, side_reg.equal, side_reg.greater};
            status_reg <= status_next;
        end
    end

    assign out_valid = p2_vld_reg;
    assign value     = value_reg;
    assign less      = flags_reg[2];
    assign equal     = flags_reg[1];
    assign greater   = flags_reg[0];
    assign status    = status_reg;
endmodule

[hdl/fpa_checker.sv]
module fpa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               valid,
    input logic               ready,
    input logic signed [31:0] value,
    input logic               less,
    input logic               equal,
    input logic               greater,
    input logic [1:0]         status
);
    import fpa_pkg::*;

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $onehot({less, equal, greater}))
        else $error("comparison flags not one-hot");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (status == ST_OK || status == ST_OVF || status == ST_DIV0))
        else $error("unknown status code");

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && status == ST_DIV0) |-> (value == 32'sd0))
        else $error("divide by zero with non-zero value");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && status == ST_OVF) |-> (value == SAT_MAX || value == SAT_MIN))
        else $error("overflow without saturated value");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=> (valid && $stable(value) && $stable(status)))
        else $error("stalled transaction changed");
endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid   (rsp.valid),
    .ready   (rsp.ready),
    .value   (rsp.value),
    .less    (rsp.less),
    .equal   (rsp.equal),
    .greater (rsp.greater),
    .status  (rsp.status)
);

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    typedef struct {
        logic [3:0]         kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } op_t;

    typedef struct {
        logic signed [31:0] value;
        logic               less;
        logic               equal;
        logic               greater;
        logic [1:0]         status;
    } res_t;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fpa_req_if req ();
    fpa_rsp_if rsp ();

    fixed_point_alu_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #10 clk = ~clk;

    op_t    pending_ops[$];
    res_t   expected_res[$];
    int     mismatches = 0;
    int     checked = 0;
    int     unexpected = 0;
    bit     stim_done = 1'b0;
    bit     hold_off = 1'b0;
    int     send_gap = 0;
    int     take_gap = 0;
    int     kind_seen[16];

    function automatic longint clamp_q(longint v, inout logic [1:0] st);
        if (v > Q_MAX)
        begin
            st = ST_OVF;
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            st = ST_OVF;
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic res_t alu_predict(op_t op);
        res_t        r;
        longint      a;
        longint      b;
        longint      v;
        logic [1:0]  st;
        bit          neg;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] m;
        a  = op.a;
        b  = op.b;
        v  = 0;
        st = ST_OK;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        case (op.kind)
            KIND_ADD:   v = clamp_q(a + b, st);
            KIND_SUB:   v = clamp_q(a - b, st);
            KIND_MUL:
            begin
                m = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                v = clamp_q(neg ? -longint'(m) : longint'(m), st);
            end
            KIND_DIV:
            begin
                if (b == 0)
                    st = ST_DIV0;
                else
                begin
                    m = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
                    v = clamp_q(neg ? -longint'(m) : longint'(m), st);
                end
            end
            KIND_INC:   v = clamp_q(a + 1, st);
            KIND_DEC:   v = clamp_q(a - 1, st);
            KIND_TOI:   v = a / (64'sd1 <<< FRAC_BITS);
            KIND_FROMI: v = clamp_q(a * (64'sd1 <<< FRAC_BITS), st);
            KIND_MIN:   v = (a < b) ? a : b;
            KIND_MAX:   v = (a > b) ? a : b;
            default:    v = 0;
        endcase
        r.value   = v[31:0];
        r.less    = a < b;
        r.equal   = a == b;
        r.greater = a > b;
        r.status  = st;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 1024))
                                           : 32'($urandom_range(0, 1024));
            3: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 2 ** 20))
                                           : 32'($urandom_range(0, 2 ** 20));
            4: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [3:0] k, logic signed [31:0] a, logic signed [31:0] b);
        op_t op;
        op.kind = k;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.kind  <= '0;
            req.a_raw <= '0;
            req.b_raw <= '0;
            send_gap  <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
                expected_res.push_back(alu_predict('{req.kind, req.a_raw, req.b_raw}));
            if (send_gap > 0 || hold_off || pending_ops.size() == 0)
            begin
                req.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                op_t op;
                op = pending_ops.pop_front();
                req.valid <= 1'b1;
                req.kind  <= op.kind;
                req.a_raw <= op.a;
                req.b_raw <= op.b;
                kind_seen[op.kind] <= kind_seen[op.kind] + 1;
                send_gap  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            take_gap  <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                res_t want;
                if (expected_res.size() == 0)
                begin
                    unexpected++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result value=%0d", rsp.value);
                end
                else
                begin
                    want = expected_res.pop_front();
                    checked++;
                    if (rsp.value !== want.value || rsp.less !== want.less ||
                        rsp.equal !== want.equal || rsp.greater !== want.greater ||
                        rsp.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp v=%0d l%0b e%0b g%0b st%0d, got v=%0d l%0b e%0b g%0b st%0d",
                                     want.value, want.less, want.equal, want.greater,
                                     want.status, rsp.value, rsp.less, rsp.equal,
                                     rsp.greater, rsp.status);
                    end
                end
            end
            if (take_gap > 0)
            begin
                rsp.ready <= 1'b0;
                take_gap  <= take_gap - 1;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (rsp.valid && rsp.ready && $urandom_range(0, 3) == 0)
                    take_gap <= $urandom_range(0, 8);
            end
        end
    end

    initial
    begin
        logic signed [31:0] edge_vals[6];
        edge_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, -1, 32'sh0000_0100};
        add_op(KIND_ADD, 32'sh7FFF_FFFF, 1);
        add_op(KIND_SUB, 32'sh8000_0000, 1);
        add_op(KIND_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_op(KIND_MUL, 32'sh8000_0000, 32'sh8000_0000);
        add_op(KIND_MUL, 32'sh0000_0180, -1);
        add_op(KIND_MUL, 1, 128);
        add_op(KIND_DIV, 5, 0);
        add_op(KIND_DIV, 32'sh8000_0000, -1);
        add_op(KIND_DIV, 32'sh8000_0000, 32'sh8000_0000);
        add_op(KIND_DIV, 1, 512);
        add_op(KIND_DIV, -1, 512);
        add_op(KIND_INC, 32'sh7FFF_FFFF, 0);
        add_op(KIND_DEC, 32'sh8000_0000, 0);
        add_op(KIND_TOI, -257, 3);
        add_op(KIND_TOI, 32'sh8000_0000, 0);
        add_op(KIND_FROMI, 32'sh0080_0000, 0);
        add_op(KIND_FROMI, 32'sh8000_0000, 0);
        add_op(KIND_FROMI, -5, 0);
        add_op(KIND_MIN, -3, 7);
        add_op(KIND_MAX, -3, 7);
        add_op(KIND_MAX, 4, 4);
        add_op(4'd10, 3, 9);
        add_op(4'd15, 32'sh7FFF_FFFF, 32'sh8000_0000);
        add_op(KIND_ADD, 32'shFFFF_FFFF, 32'shFFFF_FFFF);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 1750; i++)
        begin
            logic [3:0] k;
            logic signed [31:0] a;
            logic signed [31:0] b;
            k = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            a = rand_operand();
            b = ($urandom_range(0, 9) == 0) ? a : rand_operand();
            if (k == KIND_DIV && $urandom_range(0, 15) == 0)
                b = 0;
            add_op(k, a, b);
            if (i == 800)
            begin
                wait (pending_ops.size() == 0);
                @(posedge clk);
                hold_off = 1'b1;
                wait (expected_res.size() == 0 && !req.valid);
                @(posedge clk);
                hold_off = 1'b0;
            end
        end
        wait (pending_ops.size() == 0);
        @(posedge clk);
        wait (!req.valid && expected_res.size() == 0);
        repeat (100) @(posedge clk);
        $display("Checked %0d results over kinds add..max plus unused codes, saturation,",
                 checked);
        $display("divide by zero and rounding cases; add=%0d div=%0d unused=%0d",
                 kind_seen[0], kind_seen[3], kind_seen[10] + kind_seen[15]);
        if (mismatches == 0 && expected_res.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

endmodule
